>>> hw/rtl/cwg_pkg.sv
// shared types and constants of the convolution window geometry block
package cwg_pkg;

  // fixed field widths
  localparam int OUT_W = 25;
  localparam int PAD_W = 8;

  // tuser layout on the slave side: op, pad_mode, target_given
  localparam int TU_OP     = 0;
  localparam int TU_MODE   = 1;
  localparam int TU_TG     = 3;
  localparam int S_TUSER_W = 4;
  localparam int M_TUSER_W = 1;

  // quotient bits resolved per divider stage
  localparam int DIV_BITS_PER_STAGE = 2;

  typedef enum logic {
    OP_FORWARD    = 1'b0,
    OP_TRANSPOSED = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PAD_EXPLICIT   = 2'd0,
    PAD_VALID      = 2'd1,
    PAD_SAME_UPPER = 2'd2,
    PAD_SAME_LOWER = 2'd3
  } pad_mode_e;

endpackage

>>> hw/rtl/cwg_div.sv
// pipelined restoring divider with a side payload that travels alongside
module cwg_div #(
  parameter int NUM_W  = 18,
  parameter int DEN_W  = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [NUM_W-1:0]  in_num_i,
  input  logic [DEN_W-1:0]  in_den_i,
  input  logic [SIDE_W-1:0] in_side_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [NUM_W-1:0]  out_quo_o,
  output logic [DEN_W-1:0]  out_rem_o,
  output logic [SIDE_W-1:0] out_side_o
);
  import cwg_pkg::*;

  localparam int STEPS  = DIV_BITS_PER_STAGE;
  localparam int NSTG   = (NUM_W + STEPS - 1) / STEPS;
  localparam int WORK_W = NSTG * STEPS;

  // nq holds the numerator bits still to shift in, quotient bits fill from the bottom
  typedef struct packed {
    logic [WORK_W-1:0] nq;
    logic [DEN_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [SIDE_W-1:0] side;
  } div_stage_t;

  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t r;
    logic [DEN_W:0] t;
    logic q;
    r = s;
    for (int k = 0; k < STEPS; k++) begin
      t = {r.rem, r.nq[WORK_W-1]};
      q = (t >= {1'b0, r.den});
      if (q) begin
        t = t - {1'b0, r.den};
      end
      r.rem = t[DEN_W-1:0];
      r.nq  = {r.nq[WORK_W-2:0], q};
    end
    return r;
  endfunction

  div_stage_t        stg_q [NSTG];
  logic              vld_q [NSTG];
  logic [NSTG:0]     rdy;

  assign rdy[NSTG] = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    div_stage_t cur;
    logic       cur_v;

    if (g == 0) begin : g_first
      assign cur = '{nq: WORK_W'(in_num_i), rem: '0, den: in_den_i, side: in_side_i};
      assign cur_v = in_valid_i;
    end else begin : g_next
      assign cur   = stg_q[g-1];
      assign cur_v = vld_q[g-1];
    end

    assign rdy[g] = !vld_q[g] || rdy[g+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (rdy[g]) begin
        vld_q[g] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[g] && cur_v) begin
        stg_q[g] <= div_step(cur);
      end
    end
  end

  assign out_valid_o = vld_q[NSTG-1];
  assign out_quo_o   = stg_q[NSTG-1].nq[NUM_W-1:0];
  assign out_rem_o   = stg_q[NSTG-1].rem;
  assign out_side_o  = stg_q[NSTG-1].side;

endmodule

>>> hw/rtl/conv_window_geometry_core.sv
// top level of the convolution window geometry block
//
// one item describes one spatial axis of a convolution or pooling layer; the
// block returns the output length of that axis and the resolved begin and end
// padding, plus an invalid flag when no length could be formed
// slave channel s_axis_*: item fields in tdata, op / pad_mode / target_given
// in tuser; master channel m_axis_*: out_size / pad_begin / pad_end in tdata,
// invalid in tuser
// pipeline: one stage of multipliers (dilated span, transposed base length),
// one stage of adders, a restoring divider by the stride that resolves two
// quotient bits per stage, and a result register
// throughput: one item per cycle while m_axis_tready_i does not stall the output; every stage advances independently
// stall: each stage holds while the one after it is full and stalled, so bubbles close up
// and s_axis_tready_o only falls once every stage holds an item
// reset: all valid bits clear at once, so the block is ready when
// rst_ni rises; there is no configuration and no stored state
module conv_window_geometry_core #(
  parameter int SIZE_BITS   = 16,
  parameter int KERNEL_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  // in_size, kernel_size, stride, dilation, pad_begin_in, pad_end_in,
  // extra_out_pad, target_size, zero fill
  input  logic [((2*SIZE_BITS+3*KERNEL_BITS+3*cwg_pkg::PAD_W+7)/8)*8-1:0] s_axis_tdata_i,
  // op, pad_mode, target_given
  input  logic [cwg_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // out_size, pad_begin, pad_end, zero fill
  output logic [((3*cwg_pkg::OUT_W+7)/8)*8-1:0] m_axis_tdata_o,
  // invalid
  output logic [cwg_pkg::M_TUSER_W-1:0] m_axis_tuser_o,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i
);
  import cwg_pkg::*;

  localparam int S         = SIZE_BITS;
  localparam int K         = KERNEL_BITS;
  localparam int M_TDATA_W = ((3*OUT_W + 7) / 8) * 8;

  // field offsets in s_axis_tdata_i
  localparam int OFF_KER  = S;
  localparam int OFF_STR  = OFF_KER + K;
  localparam int OFF_DIL  = OFF_STR + K;
  localparam int OFF_PB   = OFF_DIL + K;
  localparam int OFF_PE   = OFF_PB + PAD_W;
  localparam int OFF_OPAD = OFF_PE + PAD_W;
  localparam int OFF_TGT  = OFF_OPAD + PAD_W;

  // internal widths
  localparam int SPAN_W = 2 * K;                       // span - 1 = dilation * (kernel - 1)
  localparam int PT_W   = S + K;                       // (in_size - 1) * stride
  localparam int WIDE_W = (PT_W > SPAN_W) ? PT_W : SPAN_W;
  localparam int NAT_W  = WIDE_W + 2;                  // transposed natural length
  localparam int DNUM_W = S + 2;                       // divider numerator
  localparam int FNUM_W = ((DNUM_W > SPAN_W) ? DNUM_W : SPAN_W) + 1;
  localparam int PBE_W  = PAD_W + 1;

  typedef struct packed {
    op_e               op;
    pad_mode_e         mode;
    logic              tg;
    logic [S-1:0]      isz;
    logic [K-1:0]      str;
    logic [SPAN_W-1:0] span_m1;
    logic [PT_W-1:0]   prod_tr;
    logic [PAD_W-1:0]  pb;
    logic [PAD_W-1:0]  pe;
    logic [PAD_W-1:0]  opad;
    logic [S-1:0]      tgt;
  } s1_t;

  // everything the result stage needs besides quotient and remainder
  typedef struct packed {
    op_e               op;
    pad_mode_e         mode;
    logic              tg;
    logic              bad_f;
    logic [SPAN_W-1:0] span_m1;
    logic [PAD_W-1:0]  pb;
    logic [PAD_W-1:0]  pe;
    logic [NAT_W-1:0]  nat;
    logic [NAT_W-1:0]  tgt_eff;
    logic [PBE_W-1:0]  pbe;
  } side_t;

  typedef struct packed {
    logic [DNUM_W-1:0] num;
    logic [K-1:0]      den;
    side_t             side;
  } s2_t;

  typedef struct packed {
    logic [OUT_W-1:0] osz;
    logic [OUT_W-1:0] pb;
    logic [OUT_W-1:0] pe;
    logic             bad;
  } res_t;

  // ---------------------------------------------------------------------------
  // stage 1: sanitize fields and form the two products
  // ---------------------------------------------------------------------------
  s1_t  s1_d, s1_q;
  logic s1_v_q;
  logic s1_rdy, s2_rdy;

  always_comb begin
    logic [S-1:0]     isz_raw;
    logic [K-1:0]     ker_raw;
    logic [K-1:0]     str_raw;
    logic [K-1:0]     dil;
    logic [S-1:0]     isz1;
    logic [K-1:0]     ker_m1;
    logic [K-1:0]     str1;
    pad_mode_e        mode;
    isz_raw = s_axis_tdata_i[S-1:0];
    ker_raw = s_axis_tdata_i[OFF_KER +: K];
    str_raw = s_axis_tdata_i[OFF_STR +: K];
    dil     = s_axis_tdata_i[OFF_DIL +: K];
    mode    = pad_mode_e'(s_axis_tuser_i[TU_MODE +: 2]);
    // zero in_size, kernel and stride count as one
    isz1    = (isz_raw == '0) ? S'(1) : isz_raw;
    ker_m1  = (ker_raw == '0) ? '0 : ker_raw - K'(1);
    str1    = (str_raw == '0) ? K'(1) : str_raw;

    s1_d.op      = op_e'(s_axis_tuser_i[TU_OP]);
    s1_d.mode    = mode;
    s1_d.tg      = s_axis_tuser_i[TU_TG];
    s1_d.isz     = isz1;
    s1_d.str     = str1;
    s1_d.span_m1 = SPAN_W'(dil) * SPAN_W'(ker_m1);
    s1_d.prod_tr = PT_W'(isz1 - S'(1)) * PT_W'(str1);
    // valid mode drops the explicit pads
    s1_d.pb      = (mode == PAD_VALID) ? '0 : s_axis_tdata_i[OFF_PB +: PAD_W];
    s1_d.pe      = (mode == PAD_VALID) ? '0 : s_axis_tdata_i[OFF_PE +: PAD_W];
    s1_d.opad    = s_axis_tdata_i[OFF_OPAD +: PAD_W];
    s1_d.tgt     = s_axis_tdata_i[OFF_TGT +: S];
  end

  assign s1_rdy          = !s1_v_q || s2_rdy;
  assign s_axis_tready_o = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && s_axis_tvalid_i) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: forward numerator and transposed lengths
  // ---------------------------------------------------------------------------
  s2_t  s2_d, s2_q;
  logic s2_v_q;
  logic div_in_rdy;

  always_comb begin
    logic [FNUM_W-1:0] fwd_sum;
    logic [FNUM_W-1:0] span_x;
    logic              bad_f;
    logic              same;
    fwd_sum = FNUM_W'(s1_q.isz) + FNUM_W'(s1_q.pb) + FNUM_W'(s1_q.pe);
    span_x  = FNUM_W'(s1_q.span_m1);
    // padded input shorter than the window span
    bad_f   = (fwd_sum <= span_x);
    same    = (s1_q.mode == PAD_SAME_UPPER) || (s1_q.mode == PAD_SAME_LOWER);

    // same modes divide in_size - 1 (ceiling division), the rest the numerator
    if (same) begin
      s2_d.num = DNUM_W'(s1_q.isz - S'(1));
    end else if (bad_f) begin
      s2_d.num = '0;
    end else begin
      s2_d.num = DNUM_W'(fwd_sum - span_x - FNUM_W'(1));
    end
    s2_d.den = s1_q.str;

    s2_d.side.op      = s1_q.op;
    s2_d.side.mode    = s1_q.mode;
    s2_d.side.tg      = s1_q.tg;
    s2_d.side.bad_f   = bad_f;
    s2_d.side.span_m1 = s1_q.span_m1;
    s2_d.side.pb      = s1_q.pb;
    s2_d.side.pe      = s1_q.pe;
    s2_d.side.nat     = NAT_W'(s1_q.prod_tr) + NAT_W'(s1_q.span_m1)
                      + NAT_W'(s1_q.opad) + NAT_W'(1);
    // without a prescribed size the target is in_size * stride
    s2_d.side.tgt_eff = s1_q.tg ? NAT_W'(s1_q.tgt)
                                : NAT_W'(s1_q.prod_tr) + NAT_W'(s1_q.str);
    s2_d.side.pbe     = PBE_W'(s1_q.pb) + PBE_W'(s1_q.pe);
  end

  assign s2_rdy = !s2_v_q || div_in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q) begin
      s2_q <= s2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // divider by the stride
  // ---------------------------------------------------------------------------
  logic                     div_out_v;
  logic                     out_rdy;
  logic [DNUM_W-1:0]        div_quo;
  logic [K-1:0]             div_rem;
  logic [$bits(side_t)-1:0] div_side_raw;
  side_t                    div_side;

  cwg_div #(
    .NUM_W  (DNUM_W),
    .DEN_W  (K),
    .SIDE_W ($bits(side_t))
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_v_q),
    .in_ready_o  (div_in_rdy),
    .in_num_i    (s2_q.num),
    .in_den_i    (s2_q.den),
    .in_side_i   (s2_q.side),
    .out_valid_o (div_out_v),
    .out_ready_i (out_rdy),
    .out_quo_o   (div_quo),
    .out_rem_o   (div_rem),
    .out_side_o  (div_side_raw)
  );

  assign div_side = side_t'(div_side_raw);

  // ---------------------------------------------------------------------------
  // result stage: resolve length and pads, register toward the master side
  // ---------------------------------------------------------------------------
  res_t m_d, m_q;
  logic m_v_q;

  always_comb begin
    logic [SPAN_W-1:0] f_tot;
    logic [SPAN_W-1:0] f_half;
    logic [SPAN_W-1:0] f_big;
    logic [OUT_W-1:0]  f_osz;
    logic              t_neg;
    logic [NAT_W-1:0]  t_tot;
    logic [NAT_W-1:0]  t_half;
    logic [NAT_W-1:0]  t_big;
    logic              x_neg;
    logic              same;
    logic              upper;
    same   = (div_side.mode == PAD_SAME_UPPER) || (div_side.mode == PAD_SAME_LOWER);
    upper  = (div_side.mode == PAD_SAME_UPPER);

    // forward same: total pad is span - 1 - remainder, clamped at zero
    f_tot  = (div_side.span_m1 > SPAN_W'(div_rem)) ? div_side.span_m1 - SPAN_W'(div_rem)
                                                   : '0;
    f_half = f_tot >> 1;
    f_big  = f_half + SPAN_W'(f_tot[0]);
    f_osz  = OUT_W'(div_quo) + OUT_W'(1);

    // transposed target or same: total pad is natural - target
    t_neg  = (div_side.tgt_eff > div_side.nat);
    t_tot  = div_side.nat - div_side.tgt_eff;
    t_half = t_tot >> 1;
    t_big  = t_half + NAT_W'(t_tot[0]);

    // transposed explicit: pads larger than the natural length
    x_neg  = (NAT_W'(div_side.pbe) > div_side.nat);

    m_d = '0;
    if (div_side.op == OP_FORWARD) begin
      if (same) begin
        m_d.osz = f_osz;
        m_d.pb  = OUT_W'(upper ? f_half : f_big);
        m_d.pe  = OUT_W'(upper ? f_big : f_half);
      end else begin
        m_d.bad = div_side.bad_f;
        m_d.osz = div_side.bad_f ? '0 : f_osz;
        m_d.pb  = OUT_W'(div_side.pb);
        m_d.pe  = OUT_W'(div_side.pe);
      end
    end else if (same || div_side.tg) begin
      // a negative total leaves both pads at zero; every mode but same upper puts the
      // larger half first
      if (!t_neg) begin
        m_d.pb = OUT_W'(upper ? t_half : t_big);
        m_d.pe = OUT_W'(upper ? t_big : t_half);
      end
      m_d.osz = OUT_W'((t_neg && !div_side.tg) ? div_side.nat : div_side.tgt_eff);
    end else begin
      m_d.bad = x_neg;
      m_d.osz = x_neg ? '0 : OUT_W'(div_side.nat - NAT_W'(div_side.pbe));
      m_d.pb  = OUT_W'(div_side.pb);
      m_d.pe  = OUT_W'(div_side.pe);
    end
  end

  assign out_rdy = !m_v_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (out_rdy) begin
      m_v_q <= div_out_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && div_out_v) begin
      m_q <= m_d;
    end
  end

  assign m_axis_tvalid_o = m_v_q;
  assign m_axis_tdata_o  = M_TDATA_W'({m_q.pe, m_q.pb, m_q.osz});
  assign m_axis_tuser_o  = M_TUSER_W'(m_q.bad);

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // an invalid axis always reports a zero output length
  a_invalid_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o[OUT_W-1:0] == '0)
    else $error("invalid item with nonzero out_size");

  // the input side only backs up once the output is stalled with a result
  a_backpressure_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled while the pipeline can still move");

  // a blocked first stage keeps its item
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !s2_rdy |=> s1_v_q && $stable(s1_q))
    else $error("first stage lost or changed a stalled item");

  // a blocked second stage keeps its item
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && !div_in_rdy |=> s2_v_q && $stable(s2_q))
    else $error("second stage lost or changed a stalled item");

endmodule
